// ===== rtl/mimu_pkg.sv =====
// Shared types and constants of the inter-processor interrupt mailbox unit.
package mimu_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 2;
  localparam int DATA_W = 64;
  localparam int IRQC_W = 4;

  localparam logic [7:0] OFS_STATUS   = 8'h00;
  localparam logic [7:0] OFS_ENABLE   = 8'h04;
  localparam logic [7:0] OFS_SET      = 8'h08;
  localparam logic [7:0] OFS_CLEAR    = 8'h0c;
  localparam logic [7:0] OFS_MBOX     = 8'h20;
  localparam logic [7:0] OFS_SEND     = 8'h40;
  localparam logic [7:0] OFS_MAILSEND = 8'h48;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_MISALIGN = 2'd2,
    ST_RANGE    = 2'd3
  } mimu_status_t;

  // Byte-lane mask of an access of 2**size bytes starting at lane 0.
  function automatic logic [7:0] size_mask(input logic [SIZE_W-1:0] size);
    logic [7:0] m;
    case (size)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0f;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/mimu_req_if.sv =====
// Request channel: one register access per beat.
interface mimu_req_if;
  import mimu_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] access_address;
  logic [SIZE_W-1:0] access_size;
  logic [DATA_W-1:0] write_data;

  modport source(output valid, action, access_address, access_size, write_data,
                 input ready);
  modport sink(input valid, action, access_address, access_size, write_data,
               output ready);
endinterface

// ===== rtl/mimu_rsp_if.sv =====
// Response channel: one access result per beat.
interface mimu_rsp_if;
  import mimu_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_valid;
  logic [IRQC_W-1:0] irq_core;
  logic              irq_raise;
  logic [1:0]        access_status;

  modport source(output valid, read_data, irq_valid, irq_core, irq_raise, access_status,
                 input ready);
  modport sink(input valid, read_data, irq_valid, irq_core, irq_raise, access_status,
               output ready);
endinterface

// ===== rtl/mimu_ram.sv =====
// Generic single-port RAM with registered read.
module mimu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/multicore_ipi_mailbox_unit_core.sv =====
// Per-core IPI status, enable and mailbox registers. After reset the block first runs a
// clearing pass over all NUM_CORES * 2**WORD_BITS mailbox RAM entries (64 entries at
// the default settings, with WORD_BITS = max(1, clog2(ceil(MAILBOX_BYTES/8)))), and holds
// req.ready low meanwhile. From then on it takes one access per cycle while no result
// waits on rsp: an access is registered, decoded and applied in the following cycle, and
// its result passes through the stage 2 register onto rsp. Status and enable words live
// in flip-flops so a status read-modify-write completes in that same cycle; the mailbox
// sits in one RAM per byte lane whose registered read port delivers read data alongside
// the stage 2 result. The pipeline stalls as a whole while a result waits on rsp.
module multicore_ipi_mailbox_unit_core #(
  parameter int NUM_CORES     = 16,
  parameter int MAILBOX_BYTES = 32
) (
  input logic clk,
  input logic rst,
  mimu_req_if.sink   req,
  mimu_rsp_if.source rsp
);
  import mimu_pkg::*;

  localparam int CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int WPC       = (MAILBOX_BYTES + 7) / 8;
  localparam int WORD_BITS = (WPC > 1) ? $clog2(WPC) : 1;
  localparam int MB_DEPTH  = NUM_CORES * (1 << WORD_BITS);
  localparam int MB_AW     = $clog2(MB_DEPTH);
  localparam logic [10:0] NUM_CORES_C = 11'(NUM_CORES);
  localparam logic [5:0]  MB_BYTES_C  = 6'(MAILBOX_BYTES);
  localparam logic [8:0]  MB_END_C    = 9'(OFS_MBOX) + 9'(MAILBOX_BYTES);

  // Clearing pass over the mailbox RAM.
  logic             clr_active;
  logic [MB_AW-1:0] clr_addr;

  // Stage 1: registered access.
  logic              s1_valid;
  logic              s1_action;
  logic [ADDR_W-1:0] s1_addr;
  logic [SIZE_W-1:0] s1_size;
  logic [DATA_W-1:0] s1_data;

  // Stage 2: registered result.
  logic              s2_valid;
  logic [DATA_W-1:0] s2_rd;
  logic              s2_irqv;
  logic [IRQC_W-1:0] s2_irqc;
  logic              s2_irqr;
  mimu_status_t      s2_status;
  logic              s2_mbox_rd;
  logic [2:0]        s2_lane;
  logic [SIZE_W-1:0] s2_size;

  logic [31:0] pending_status [NUM_CORES];
  logic [31:0] enable_word    [NUM_CORES];

  logic advance;

  // Decode of the stage 1 access.
  logic [7:0]          core;
  logic [7:0]          ofs;
  logic [9:0]          target;
  logic [7:0]          lane_mask;
  logic [5:0]          mb_byte;
  logic                core_bad;
  logic                target_bad;
  logic [CORE_W-1:0]   pend_idx;
  logic [31:0]         pend_cur;
  logic [31:0]         pend_new;
  logic                pend_we;
  logic                en_we;
  logic                do_send;
  mimu_status_t        st;
  logic [DATA_W-1:0]   rd;
  logic                irqv;
  logic [IRQC_W-1:0]   irqc;
  logic                irqr;
  logic                mb_we;
  logic                mb_re;
  logic [7:0]          mb_be;
  logic [DATA_W-1:0]   mb_wdata;
  logic [CORE_W-1:0]   mb_core;
  logic [WORD_BITS-1:0] mb_word;
  logic [MB_AW-1:0]    ram_addr;
  logic [DATA_W-1:0]   ram_rdata;
  logic [DATA_W-1:0]   rd_shift;
  logic [DATA_W-1:0]   rd_mask;
  logic [7:0]          rd_lanes;

  // Access length in bytes, 1 to 8.
  function automatic logic [3:0] lane_mask_len(input logic [SIZE_W-1:0] size);
    return 4'd1 << size;
  endfunction

  assign advance   = !s2_valid || rsp.ready;
  assign req.ready = advance && !clr_active;

  assign core      = s1_addr[15:8];
  assign ofs       = s1_addr[7:0];
  assign target    = s1_data[25:16];
  assign lane_mask = size_mask(s1_size);
  assign mb_byte   = 6'(ofs - OFS_MBOX);
  assign core_bad   = 11'(core) >= NUM_CORES_C;
  assign target_bad = 11'(target) >= NUM_CORES_C;
  assign do_send    = (ofs == OFS_SEND) && s1_action;
  assign pend_idx   = do_send ? target[CORE_W-1:0] : core[CORE_W-1:0];
  assign pend_cur   = pending_status[pend_idx];

  always_comb begin
    st       = ST_OK;
    rd       = '0;
    irqv     = 1'b0;
    irqc     = '0;
    irqr     = 1'b0;
    pend_we  = 1'b0;
    pend_new = pend_cur;
    en_we    = 1'b0;
    mb_we    = 1'b0;
    mb_re    = 1'b0;
    mb_be    = '0;
    mb_wdata = '0;
    mb_core  = core[CORE_W-1:0];
    mb_word  = mb_byte[3 +: WORD_BITS];

    if ((ofs[2:0] & 3'(lane_mask_len(s1_size) - 4'd1)) != 3'd0) begin
      st = ST_MISALIGN;
    end else if (ofs == OFS_STATUS || ofs == OFS_ENABLE ||
                 ofs == OFS_SET || ofs == OFS_CLEAR) begin
      if (s1_action && (ofs == OFS_STATUS || ofs == OFS_SET)) begin
        st = ST_UNKNOWN;
      end else if (core_bad) begin
        st = ST_RANGE;
      end else if (!s1_action) begin
        if (ofs == OFS_STATUS) begin
          rd = 64'(pend_cur);
        end else if (ofs == OFS_ENABLE) begin
          rd = 64'(enable_word[core[CORE_W-1:0]]);
        end
      end else if (ofs == OFS_ENABLE) begin
        en_we = 1'b1;
      end else begin
        pend_we  = 1'b1;
        pend_new = pend_cur & ~s1_data[31:0];
        if (pend_new == '0) begin
          irqv = 1'b1;
          irqc = IRQC_W'(core);
        end
      end
    end else if (9'(ofs) >= 9'(OFS_MBOX) && 9'(ofs) < MB_END_C) begin
      if (mb_byte + 6'(lane_mask_len(s1_size)) > MB_BYTES_C) begin
        st = ST_UNKNOWN;
      end else if (core_bad) begin
        st = ST_RANGE;
      end else if (s1_action) begin
        mb_we    = 1'b1;
        mb_be    = lane_mask << mb_byte[2:0];
        mb_wdata = s1_data << {mb_byte[2:0], 3'b000};
      end else begin
        mb_re = 1'b1;
      end
    end else if (do_send) begin
      if (target_bad) begin
        st = ST_RANGE;
      end else begin
        pend_we  = 1'b1;
        pend_new = pend_cur | (32'd1 << s1_data[4:0]);
        if (pend_cur == '0) begin
          irqv = 1'b1;
          irqc = IRQC_W'(target);
          irqr = 1'b1;
        end
      end
    end else if (ofs == OFS_MAILSEND && s1_action) begin
      mb_core = target[CORE_W-1:0];
      mb_word = s1_data[3 +: WORD_BITS];
      if ({1'b0, s1_data[4:2], 2'b00} + 6'd4 > MB_BYTES_C) begin
        st = ST_UNKNOWN;
      end else if (target_bad) begin
        st = ST_RANGE;
      end else begin
        mb_we    = 1'b1;
        mb_be    = s1_data[2] ? 8'hf0 : 8'h0f;
        mb_wdata = s1_data[2] ? {s1_data[63:32], 32'd0} : {32'd0, s1_data[63:32]};
      end
    end else begin
      st = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      for (int i = 0; i < NUM_CORES; i++) begin
        pending_status[i] <= '0;
        enable_word[i]    <= '0;
      end
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + MB_AW'(1);
        if (clr_addr == MB_AW'(MB_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid <= req.valid && req.ready;
        s2_valid <= s1_valid;
        if (s1_valid && pend_we) begin
          pending_status[pend_idx] <= pend_new;
        end
        if (s1_valid && en_we) begin
          enable_word[core[CORE_W-1:0]] <= s1_data[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_action  <= req.action;
      s1_addr    <= req.access_address;
      s1_size    <= req.access_size;
      s1_data    <= req.write_data;
      s2_rd      <= s1_action ? '0 : rd;
      s2_irqv    <= irqv;
      s2_irqc    <= irqc;
      s2_irqr    <= irqr;
      s2_status  <= st;
      s2_mbox_rd <= mb_re;
      s2_lane    <= mb_byte[2:0];
      s2_size    <= s1_size;
    end
  end

  // One RAM per byte lane, so partial writes need no read-modify-write.
  assign ram_addr = clr_active ? clr_addr : MB_AW'({mb_core, mb_word});

  for (genvar g = 0; g < 8; g++) begin : g_lane
    mimu_ram #(
      .WIDTH(8),
      .DEPTH(MB_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (clr_active || (advance && s1_valid && mb_we && mb_be[g])),
      .re   (advance && s1_valid && mb_re),
      .addr (ram_addr),
      .wdata(clr_active ? 8'd0 : mb_wdata[8*g +: 8]),
      .rdata(ram_rdata[8*g +: 8])
    );
  end

  always_comb begin
    rd_shift = ram_rdata >> {s2_lane, 3'b000};
    rd_lanes = size_mask(s2_size);
    for (int i = 0; i < 8; i++) begin
      rd_mask[8*i +: 8] = rd_lanes[i] ? 8'hff : 8'h00;
    end
  end

  assign rsp.valid         = s2_valid;
  assign rsp.read_data     = s2_mbox_rd ? (rd_shift & rd_mask) : s2_rd;
  assign rsp.irq_valid     = s2_irqv;
  assign rsp.irq_core      = s2_irqc;
  assign rsp.irq_raise     = s2_irqr;
  assign rsp.access_status = s2_status;

  // No access may be in flight while the mailbox is being cleared.
  a_clr_idle: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s1_valid && !s2_valid)
    else $error("access in flight during mailbox clearing pass");

  // An interrupt change only comes from an access that succeeded.
  a_irq_ok: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_irqv |-> s2_status == ST_OK)
    else $error("interrupt change reported on a flagged access");

  // Flagged accesses never return data.
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_status != ST_OK |-> rsp.read_data == '0)
    else $error("read data returned on a flagged access");

  // A completed send leaves the target's status nonzero.
  a_send_sets: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && do_send && st == ST_OK |=>
      pending_status[$past(pend_idx)] != '0)
    else $error("send did not set a status bit");

  // A lowered interrupt means the status word of that core is empty.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && irqv && !irqr |=> pending_status[$past(pend_idx)] == '0)
    else $error("interrupt lowered with status bits still pending");

endmodule
